// ===== src/sssd_pkg.sv =====
`default_nettype none

package sssd_pkg;

  localparam int DigitCountDef = 4;

  localparam int ValueW = 15;
  localparam int ModeW  = 2;
  localparam int ByteW  = 8;
  localparam int DigitW = 4;
  localparam int MagW   = 15;

  // operation codes carried in s_axis_tuser
  localparam logic OP_SET     = 1'b0;
  localparam logic OP_REFRESH = 1'b1;

  // point modes
  localparam logic [ModeW-1:0] MODE_NONE  = 2'd0;
  localparam logic [ModeW-1:0] MODE_MILLI = 2'd3;

  localparam logic [ByteW-1:0] SEG_OFF   = 8'hFF;
  localparam logic [ByteW-1:0] SEG_MINUS = 8'hBF;
  localparam logic [ByteW-1:0] PT_MASK   = 8'h7F;
  localparam logic [ByteW-1:0] BLANK_HI  = 8'hFF;
  localparam logic [ByteW-1:0] BLANK_LO  = 8'h00;

  // frame phases within one digit
  localparam logic [1:0] PH_BLANK_HI = 2'd0;
  localparam logic [1:0] PH_BLANK_LO = 2'd1;
  localparam logic [1:0] PH_SEG      = 2'd2;
  localparam logic [1:0] PH_SEL      = 2'd3;

  typedef struct packed {
    logic [DigitW-1:0] val;
    logic              pt;
    logic              neg;
    logic              lit;
  } digit_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CONV  = 4'b0010,
    ST_REPLY = 4'b0100,
    ST_FRAME = 4'b1000
  } state_e;

  function automatic logic [ByteW-1:0] seg_pattern(input logic [DigitW-1:0] d);
    logic [ByteW-1:0] b;
    case (d)
      4'd0:    b = 8'hC0;
      4'd1:    b = 8'hF9;
      4'd2:    b = 8'hA4;
      4'd3:    b = 8'hB0;
      4'd4:    b = 8'h99;
      4'd5:    b = 8'h92;
      4'd6:    b = 8'h82;
      4'd7:    b = 8'hF8;
      4'd8:    b = 8'h80;
      4'd9:    b = 8'h90;
      default: b = SEG_OFF;
    endcase
    return b;
  endfunction

  function automatic logic [ByteW-1:0] seg_byte(input digit_t dg);
    logic [ByteW-1:0] b;
    b = seg_pattern(dg.val);
    if (dg.pt) b = b & PT_MASK;
    if (dg.neg) b = SEG_MINUS;
    if (!dg.lit) b = SEG_OFF;
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== src/sssd_div10.sv =====
`default_nettype none

// Divide-by-ten step unit: holds the running magnitude, gives its low
// decimal digit and replaces it by the quotient on each step.
module sssd_div10 (
  input  wire logic                          clk_i,
  input  wire logic                          load_i,
  input  wire logic [sssd_pkg::MagW-1:0]     mag_i,
  input  wire logic                          step_i,
  output      logic [sssd_pkg::DigitW-1:0]   digit_o
);

  localparam int QW = sssd_pkg::MagW - 3;

  logic [sssd_pkg::MagW-1:0]    mag_q, mag_d;
  logic [sssd_pkg::MagW+15:0]   prod;
  logic [QW-1:0]                quot;
  logic [sssd_pkg::MagW-1:0]    quot_x10;
  logic [sssd_pkg::MagW-1:0]    rem;

  // x / 10 == (x * 52429) >> 19, exact for x below 43699
  assign prod     = mag_q * 16'd52429;
  assign quot     = prod[19 +: QW];
  assign quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
  assign rem      = mag_q - quot_x10;
  assign digit_o  = rem[sssd_pkg::DigitW-1:0];

  always_comb begin
    mag_d = mag_q;
    if (load_i) begin
      mag_d = mag_i;
    end else if (step_i) begin
      mag_d = {3'b000, quot};
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
  end

endmodule

`default_nettype wire

// ===== src/seven_segment_scan_driver_unit.sv =====
`default_nettype none

// Multiplexed common-anode seven-segment scan driver for DIGIT_COUNT digits
// (digit 0 leftmost). A set beat (tuser=0) carries a signed value and a point
// mode; if in range it is split into decimal digits by a shared divide-by-ten
// unit, one digit per cycle, and then gives its single reply beat (accepted
// flag in tdata[9]). Rejected values leave the display unchanged and go
// straight to the reply state. A refresh beat (tuser=1) emits
// one scan frame of 4*DIGIT_COUNT bytes, one per cycle when the sink is
// ready: per digit, from rightmost to leftmost, 0xFF, 0x00 (latch), segment
// byte, one-hot select byte (latch). The frame sequencer sets that rate. The
// input is not ready until the previous item's last beat has been loaded out.
// display_enable is sampled into the digits when a value is stored.
module seven_segment_scan_driver_unit #(
  parameter int DIGIT_COUNT = sssd_pkg::DigitCountDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // [14:0] value, [16:15] point_mode, [23:17] zero
  input  wire logic [23:0] s_axis_tdata,
  // [0] operation
  input  wire logic        s_axis_tuser,

  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] out_byte, [8] latch_after, [9] accepted, [15:10] zero
  output      logic [15:0] m_axis_tdata,
  // [0] is_reply
  output      logic        m_axis_tuser,
  output      logic        m_axis_tlast,

  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic        cfg_data_i
);

  localparam int IW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

  function automatic int pow10(input int n);
    int r;
    r = 1;
    for (int k = 0; k < n; k++) r = r * 10;
    return r;
  endfunction

  localparam int PosMax = pow10(DIGIT_COUNT) - 1;
  localparam int NegMax = pow10(DIGIT_COUNT - 1) - 1;
  localparam logic [IW-1:0] LastIdx = IW'(DIGIT_COUNT - 1);

  sssd_pkg::state_e state_q, state_d;
  logic [IW-1:0]    idx_q, idx_d;
  logic [1:0]       phase_q, phase_d;
  logic [sssd_pkg::ModeW-1:0] mode_q, mode_d;
  logic             neg_q, neg_d;
  logic             acc_q, acc_d;
  logic             en_q;
  sssd_pkg::digit_t store_q [DIGIT_COUNT];

  logic             out_valid_q, out_valid_d;
  logic [sssd_pkg::ByteW-1:0] out_byte_q, out_byte_d;
  logic             out_latch_q, out_latch_d;
  logic             out_reply_q, out_reply_d;
  logic             out_acc_q, out_acc_d;
  logic             out_last_q, out_last_d;

  logic                       in_fire;
  logic                       out_free;
  logic signed [sssd_pkg::ValueW-1:0] in_val;
  logic [sssd_pkg::ModeW-1:0] in_mode;
  int                         val_int;
  logic                       ok_pos, ok_neg;
  logic [sssd_pkg::MagW-1:0]  in_mag;
  logic                       div_load, div_step;
  logic [sssd_pkg::DigitW-1:0] div_digit;
  logic                       store_we;
  sssd_pkg::digit_t           store_wdata;
  logic [sssd_pkg::ByteW-1:0] sel_byte;

  assign cfg_ready_o = 1'b1;

  assign in_val  = s_axis_tdata[sssd_pkg::ValueW-1:0];
  assign in_mode = s_axis_tdata[sssd_pkg::ValueW +: sssd_pkg::ModeW];
  assign val_int = int'(in_val);
  assign ok_pos  = (val_int >= 0) && (val_int <= PosMax);
  assign ok_neg  = (val_int < 0) && (-val_int <= NegMax) &&
                   (in_mode != sssd_pkg::MODE_MILLI);
  assign in_mag  = ok_neg ? sssd_pkg::MagW'(-in_val) : sssd_pkg::MagW'(in_val);

  assign s_axis_tready = (state_q == sssd_pkg::ST_IDLE) && !out_valid_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign div_load = in_fire && (s_axis_tuser == sssd_pkg::OP_SET);
  assign div_step = (state_q == sssd_pkg::ST_CONV);

  sssd_div10 u_div10 (
    .clk_i   (clk_i),
    .load_i  (div_load),
    .mag_i   (in_mag),
    .step_i  (div_step),
    .digit_o (div_digit)
  );

  assign sel_byte = sssd_pkg::ByteW'(1) << (LastIdx - idx_q);

  always_comb begin
    store_we          = (state_q == sssd_pkg::ST_CONV);
    store_wdata.val   = div_digit;
    store_wdata.pt    = (mode_q != sssd_pkg::MODE_NONE) &&
                        ((int'(idx_q) + int'(mode_q)) == DIGIT_COUNT - 1);
    store_wdata.neg   = neg_q && (idx_q == '0);
    store_wdata.lit   = en_q;
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    phase_d     = phase_q;
    mode_d      = mode_q;
    neg_d       = neg_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_byte_d  = out_byte_q;
    out_latch_d = out_latch_q;
    out_reply_d = out_reply_q;
    out_acc_d   = out_acc_q;
    out_last_d  = out_last_q;

    case (state_q)
      sssd_pkg::ST_IDLE: begin
        if (in_fire) begin
          idx_d   = LastIdx;
          phase_d = sssd_pkg::PH_BLANK_HI;
          mode_d  = in_mode;
          neg_d   = ok_neg;
          acc_d   = ok_pos || ok_neg;
          if (s_axis_tuser == sssd_pkg::OP_REFRESH) begin
            state_d = sssd_pkg::ST_FRAME;
          end else if (ok_pos || ok_neg) begin
            state_d = sssd_pkg::ST_CONV;
          end else begin
            state_d = sssd_pkg::ST_REPLY;
          end
        end
      end
      sssd_pkg::ST_CONV: begin
        if (idx_q == '0) begin
          state_d = sssd_pkg::ST_REPLY;
        end else begin
          idx_d = idx_q - 1'b1;
        end
      end
      sssd_pkg::ST_REPLY: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = '0;
          out_latch_d = 1'b0;
          out_reply_d = 1'b1;
          out_acc_d   = acc_q;
          out_last_d  = 1'b1;
          state_d     = sssd_pkg::ST_IDLE;
        end
      end
      sssd_pkg::ST_FRAME: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_reply_d = 1'b0;
          out_acc_d   = 1'b0;
          out_last_d  = 1'b0;
          out_latch_d = 1'b0;
          case (phase_q)
            sssd_pkg::PH_BLANK_HI: out_byte_d = sssd_pkg::BLANK_HI;
            sssd_pkg::PH_BLANK_LO: begin
              out_byte_d  = sssd_pkg::BLANK_LO;
              out_latch_d = 1'b1;
            end
            sssd_pkg::PH_SEG: out_byte_d = sssd_pkg::seg_byte(store_q[idx_q]);
            default: begin
              out_byte_d  = sel_byte;
              out_latch_d = 1'b1;
              out_last_d  = (idx_q == '0);
            end
          endcase
          phase_d = phase_q + 1'b1;
          if (phase_q == sssd_pkg::PH_SEL) begin
            if (idx_q == '0) begin
              state_d = sssd_pkg::ST_IDLE;
            end else begin
              idx_d = idx_q - 1'b1;
            end
          end
        end
      end
      default: state_d = sssd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sssd_pkg::ST_IDLE;
      idx_q       <= '0;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
      en_q        <= 1'b1;
      for (int k = 0; k < DIGIT_COUNT; k++) begin
        store_q[k] <= '0;
      end
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        en_q <= cfg_data_i;
      end
      if (store_we) begin
        store_q[idx_q] <= store_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q      <= mode_d;
    neg_q       <= neg_d;
    acc_q       <= acc_d;
    out_byte_q  <= out_byte_d;
    out_latch_q <= out_latch_d;
    out_reply_q <= out_reply_d;
    out_acc_q   <= out_acc_d;
    out_last_q  <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b000000, out_acc_q, out_latch_q, out_byte_q};
  assign m_axis_tuser  = out_reply_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire
